@@ sv/plt_pkg.sv @@
// Shared types and constants for the properties line tokenizer.
// Holds the result kind codes, the tokenizer state and the per-transaction result bundle.
// No dependencies.
`default_nettype none

package plt_pkg;

  // Result kind codes.
  localparam logic [2:0] KIND_KEY     = 3'd0;
  localparam logic [2:0] KIND_VALUE   = 3'd1;
  localparam logic [2:0] KIND_COMMIT  = 3'd2;
  localparam logic [2:0] KIND_DISCARD = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  // Most results that one input byte can cause.
  localparam int unsigned MaxResults = 4;

  // Tokenizer state carried from one byte to the next.
  typedef struct packed {
    logic        in_value;
    logic        space_delimited;
    logic        skip_rest;
    logic        escape_pending;
    logic        hex_collecting;
    logic [1:0]  hex_count;
    logic [15:0] hex_accum;
    logic        hex_stopped;
    logic        hex_seen_digit;
    logic        leading_blank;
    logic        key_nonempty;
    logic        value_nonempty;
    logic        error_stuck;
  } state_t;

  localparam state_t STATE_RESET = '{
    in_value:        1'b0,
    space_delimited: 1'b0,
    skip_rest:       1'b0,
    escape_pending:  1'b0,
    hex_collecting:  1'b0,
    hex_count:       2'd0,
    hex_accum:       16'd0,
    hex_stopped:     1'b0,
    hex_seen_digit:  1'b0,
    leading_blank:   1'b1,
    key_nonempty:    1'b0,
    value_nonempty:  1'b0,
    error_stuck:     1'b0
  };

  // All results caused by one input byte, in order.
  typedef struct packed {
    logic [2:0]                  count;
    logic [MaxResults-1:0][2:0]  kind;
    logic [MaxResults-1:0][7:0]  data;
  } bundle_t;

endpackage

`default_nettype wire

@@ sv/plt_step.sv @@
// Combinational next-state and result logic for one text byte.
// Depends on plt_pkg for the state, bundle and kind codes.
`default_nettype none

module plt_step (
  input  var plt_pkg::state_t  state_i,
  input  wire logic [7:0]      text_byte_i,
  input  wire logic            end_of_data_i,
  output plt_pkg::state_t      state_o,
  output plt_pkg::bundle_t     bundle_o
);

  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChN     = 8'h6E;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChU     = 8'h75;

  typedef struct packed {
    plt_pkg::state_t  s;
    plt_pkg::bundle_t b;
  } work_t;

  // Appends one result unless the bundle is already full.
  function automatic plt_pkg::bundle_t emit(plt_pkg::bundle_t b, logic [2:0] k,
                                            logic [7:0] d);
    plt_pkg::bundle_t r;
    r = b;
    if (b.count < 3'(plt_pkg::MaxResults)) begin
      r.kind[b.count[1:0]] = k;
      r.data[b.count[1:0]] = d;
      r.count = b.count + 3'd1;
    end
    return r;
  endfunction

  // Adds a byte to the key or the value, whichever is open.
  function automatic work_t add_byte(work_t w, logic [7:0] d);
    work_t r;
    r = w;
    if (w.s.in_value) begin
      r.b = emit(w.b, plt_pkg::KIND_VALUE, d);
      r.s.value_nonempty = 1'b1;
    end else begin
      r.b = emit(w.b, plt_pkg::KIND_KEY, d);
      r.s.key_nonempty = 1'b1;
    end
    return r;
  endfunction

  // Hex digit decode: bit 4 flags a valid digit.
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic plt_pkg::state_t clear_entry(plt_pkg::state_t s);
    plt_pkg::state_t r;
    r = s;
    r.in_value        = 1'b0;
    r.space_delimited = 1'b0;
    r.skip_rest       = 1'b0;
    r.key_nonempty    = 1'b0;
    r.value_nonempty  = 1'b0;
    return r;
  endfunction

  // Closes the current line: a verdict, unless an escape continues the entry.
  function automatic work_t line_end(work_t w, logic final_line);
    work_t r;
    logic  cont;
    r = w;
    cont = 1'b0;
    if (w.s.skip_rest) begin
      r.b = emit(w.b, plt_pkg::KIND_DISCARD, 8'd0);
    end else if (w.s.escape_pending) begin
      if (final_line) r.b = emit(w.b, plt_pkg::KIND_DISCARD, 8'd0);
      else cont = 1'b1;
    end else if (w.s.key_nonempty) begin
      r.b = emit(w.b, plt_pkg::KIND_COMMIT, 8'd0);
    end else begin
      r.b = emit(w.b, plt_pkg::KIND_DISCARD, 8'd0);
    end
    if (!cont) r.s = clear_entry(r.s);
    r.s.escape_pending = 1'b0;
    r.s.leading_blank  = 1'b1;
    if (final_line) r.s = plt_pkg::STATE_RESET;
    return r;
  endfunction

  // One character of a unicode escape; the fourth one expands to UTF-8, or flags an error if no hex digit was seen.
  function automatic work_t hex_char(work_t w, logic [7:0] c);
    work_t      r;
    logic [4:0] d;
    logic [15:0] cp;
    r = w;
    d = hex_digit(c);
    if (!w.s.hex_stopped) begin
      if (d[4]) begin
        r.s.hex_accum = {w.s.hex_accum[11:0], d[3:0]};
        r.s.hex_seen_digit = 1'b1;
      end else begin
        r.s.hex_stopped = 1'b1;
      end
    end
    if (w.s.hex_count != 2'd3) begin
      r.s.hex_count = w.s.hex_count + 2'd1;
    end else begin
      r.s.hex_collecting = 1'b0;
      r.s.hex_count = 2'd0;
      cp = r.s.hex_accum;
      if (!r.s.hex_seen_digit) begin
        r.b = emit(r.b, plt_pkg::KIND_ERROR, 8'd0);
        r.s.error_stuck = 1'b1;
      end else if (cp < 16'h0080) begin
        r = add_byte(r, cp[7:0]);
      end else if (cp < 16'h0800) begin
        r = add_byte(r, {3'b110, cp[10:6]});
        r = add_byte(r, {2'b10, cp[5:0]});
      end else begin
        r = add_byte(r, {4'b1110, cp[15:12]});
        r = add_byte(r, {2'b10, cp[11:6]});
        r = add_byte(r, {2'b10, cp[5:0]});
      end
      r.s.hex_accum = 16'd0;
      r.s.hex_stopped = 1'b0;
      r.s.hex_seen_digit = 1'b0;
    end
    return r;
  endfunction

  // The byte after a backslash.
  function automatic work_t escaped_char(work_t w, logic [7:0] c);
    work_t r;
    r = w;
    r.s.escape_pending = 1'b0;
    if (c == ChN) r = add_byte(r, 8'd10);
    else if (c == ChT) r = add_byte(r, 8'd9);
    else if (c == ChR) r = add_byte(r, 8'd13);
    else if (c == ChF) r = add_byte(r, 8'd12);
    else if (c == ChU) begin
      r.s.hex_collecting = 1'b1;
      r.s.hex_count = 2'd0;
      r.s.hex_accum = 16'd0;
      r.s.hex_stopped = 1'b0;
      r.s.hex_seen_digit = 1'b0;
    end else r = add_byte(r, c);
    return r;
  endfunction

  // Any byte other than a line end.
  function automatic work_t plain_char(work_t w, logic [7:0] c);
    work_t r;
    r = w;
    if (w.s.skip_rest) begin
      r = w;
    end else if (w.s.escape_pending) begin
      r = escaped_char(w, c);
    end else if (w.s.hex_collecting) begin
      r = hex_char(w, c);
    end else if (c == ChEq || c == ChColon) begin
      if (w.s.in_value) begin
        if (w.s.value_nonempty || !w.s.space_delimited) r = add_byte(r, c);
        else r.s.space_delimited = 1'b0;
      end else begin
        r.s.in_value = 1'b1;
      end
      r.s.leading_blank = 1'b0;
    end else if (c == ChSpace || c == ChTab) begin
      if (w.s.in_value) begin
        if (w.s.value_nonempty && !w.s.leading_blank) r = add_byte(r, c);
      end else if (!w.s.leading_blank) begin
        r.s.in_value = 1'b1;
        r.s.space_delimited = 1'b1;
      end
    end else if (c == ChHash || c == ChBang) begin
      if (!w.s.key_nonempty) begin
        r.s.skip_rest = 1'b1;
      end else begin
        r = add_byte(r, c);
        r.s.leading_blank = 1'b0;
      end
    end else if (c == ChBslash) begin
      r.s.escape_pending = 1'b1;
      r.s.leading_blank = 1'b0;
    end else begin
      r = add_byte(r, c);
      r.s.leading_blank = 1'b0;
    end
    return r;
  endfunction

  // Top-level decision for one byte.
  always_comb begin
    work_t w;
    w.s = state_i;
    w.b = '0;
    if (state_i.error_stuck) begin
      if (end_of_data_i) w.s = plt_pkg::STATE_RESET;
    end else if (text_byte_i == ChLf) begin
      w = line_end(w, end_of_data_i);
    end else begin
      w = plain_char(w, text_byte_i);
      if (w.s.error_stuck) begin
        if (end_of_data_i) w.s = plt_pkg::STATE_RESET;
      end else if (end_of_data_i) begin
        w = line_end(w, 1'b1);
      end
    end
    state_o  = w.s;
    bundle_o = w.b;
  end

endmodule

`default_nettype wire

@@ sv/properties_line_tokenizer.sv @@
// Top level of the properties line tokenizer: state register, result queue and drain.
// Depends on plt_pkg and plt_step.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+----------------------------------
//   in      | input     | in_valid_i / in_stall_o  | text_byte_i, end_of_data_i
//   out     | output    | out_valid_o / out_stall_i| kind_o, data_byte_o, last_o
//
// A byte is decoded in the cycle it is accepted and its results (up to four) enter a
// two-entry result queue; the state register updates at the same edge.
// One byte per cycle is taken while each byte yields at most one result and the output
// is not stalled; a byte that expands to several results is put out one result at a time.
// The input stalls only when both queue entries are occupied.
// Reset clears the tokenizer state and empties the queue.
`default_nettype none

module properties_line_tokenizer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] text_byte_i,
  input  wire logic       end_of_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      kind_o,
  output logic [7:0]      data_byte_o,
  output logic            last_o
);

  plt_pkg::state_t  state_q, state_d;
  plt_pkg::bundle_t step_bundle;
  plt_pkg::bundle_t queue_q [2];
  plt_pkg::bundle_t head;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] idx_q;
  logic       in_acc, out_acc, push, pop;

  // Per-byte decode.
  plt_step u_step (
    .state_i       (state_q),
    .text_byte_i   (text_byte_i),
    .end_of_data_i (end_of_data_i),
    .state_o       (state_d),
    .bundle_o      (step_bundle)
  );

  // Handshakes.
  assign in_stall_o  = (cnt_q == 2'd2);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_acc     = out_valid_o & ~out_stall_i;
  assign push        = in_acc & (step_bundle.count != 3'd0);

  // Current result from the head of the queue.
  assign head        = queue_q[rd_ptr_q];
  assign kind_o      = head.kind[idx_q];
  assign data_byte_o = head.data[idx_q];
  assign last_o      = ({1'b0, idx_q} == (head.count - 3'd1));
  assign pop         = out_acc & last_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (!push && pop) cnt_d = cnt_q - 2'd1;
  end

  // Tokenizer state and queue control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= plt_pkg::STATE_RESET;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
      idx_q    <= 2'd0;
    end else begin
      if (in_acc) state_q <= state_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
        idx_q    <= 2'd0;
      end else if (out_acc) begin
        idx_q <= idx_q + 2'd1;
      end
      cnt_q <= cnt_d;
    end
  end

  // Queue payload.
  always_ff @(posedge clk_i) begin
    if (push) queue_q[wr_ptr_q] <= step_bundle;
  end

endmodule

`default_nettype wire
